// ===== hw/rtl/tcnl_pkg.sv =====
`timescale 1ns / 1ps

package tcnl_pkg;

  // Stream payload widths
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned IPV4_W      = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned TTL_W       = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IN_TDATA_W  = KEY_W + IPV4_W + TIME_W;
  localparam int unsigned OUT_TDATA_W = IPV4_W + 3 * CNT_W;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [TTL_W-1:0] TTL_RESET = 16'd300;

  // Register index (byte address / 4)
  localparam logic REG_TTL = 1'b0;

  // Request kinds
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_HIT       = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CACHE_SCAN,
    S_RECORD_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/ttl_cached_name_lookup.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_      slave      tuser: req_type; tdata: domain_key, address_in, now_seconds
// out_     master     tuser: status; tdata: result_address, total_lookups,
//                     total_hits, total_misses
// cfg_     APB slave  register 0 at byte 0: ttl_seconds (16 bits)
//
// An add is accepted, then its result is loaded. A lookup, after its accept, scans
// the cache memory and then the record memory one entry per cycle through their
// single read ports, and then loads its result.
// A cache hit ends the lookup in the cache scan, with no record scan.
// rst_n is synchronous; counters, fills and ttl_seconds reset, memories do not.
// One item at a time; the next item is accepted while a result waits on out_.

module ttl_cached_name_lookup #(
  parameter int unsigned RECORD_DEPTH = 64,
  parameter int unsigned CACHE_DEPTH  = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tcnl_pkg::IN_TDATA_W-1:0]      in_tdata,  // domain_key, address_in, now_seconds
  input  logic                                 in_tuser,  // req_type
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tcnl_pkg::OUT_TDATA_W-1:0]     out_tdata, // result_address, lookups, hits, misses
  output logic [tcnl_pkg::STATUS_W-1:0]        out_tuser, // status
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [tcnl_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [tcnl_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [tcnl_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  import tcnl_pkg::*;

  localparam int unsigned RAW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CCW = $clog2(CACHE_DEPTH + 1);
  localparam logic [RCW-1:0] REC_FULL   = RCW'(RECORD_DEPTH);
  localparam logic [CCW-1:0] CACHE_FULL = CCW'(CACHE_DEPTH);

  // Memories
  logic [KEY_W-1:0]  rec_key_mem   [RECORD_DEPTH];
  logic [IPV4_W-1:0] rec_addr_mem  [RECORD_DEPTH];
  logic [KEY_W-1:0]  cache_key_mem [CACHE_DEPTH];
  logic [IPV4_W-1:0] cache_addr_mem[CACHE_DEPTH];
  logic [TIME_W-1:0] cache_time_mem[CACHE_DEPTH];

  logic [KEY_W-1:0]  rec_key_q;
  logic [IPV4_W-1:0] rec_addr_q;
  logic [KEY_W-1:0]  cache_key_q;
  logic [IPV4_W-1:0] cache_addr_q;
  logic [TIME_W-1:0] cache_time_q;

  logic              rec_we;
  logic              cache_we;
  logic [KEY_W-1:0]  in_key;
  logic [IPV4_W-1:0] in_addr;
  logic [TIME_W-1:0] in_now;

  // Control and item registers
  state_t            state_r, state_nxt;
  logic [RCW-1:0]    rec_fill_r, rec_fill_nxt;
  logic [CCW-1:0]    cache_fill_r, cache_fill_nxt;
  logic [RCW-1:0]    rptr_r, rptr_nxt;
  logic [CCW-1:0]    cptr_r, cptr_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  lookups_r, lookups_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [CNT_W-1:0]  misses_r, misses_nxt;
  logic [TTL_W-1:0]  ttl_r;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [IPV4_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]    out_user_r;

  logic              in_xfer;
  logic              out_load;
  logic              cache_hit;
  logic              cache_done;
  logic              rec_found;
  logic              rec_done;
  logic [TIME_W-1:0] age;
  logic              cfg_wr;

  assign in_key  = in_tdata[KEY_W-1:0];
  assign in_addr = in_tdata[KEY_W +: IPV4_W];
  assign in_now  = in_tdata[KEY_W+IPV4_W +: TIME_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_vld_r || out_tready);

  // Scan checks on the registered read data
  assign age        = now_r - cache_time_q;
  assign cache_hit  = pend_r && (cache_key_q == key_r) && (age < {16'd0, ttl_r});
  assign cache_done = !pend_r && (cptr_r >= cache_fill_r);
  assign rec_found  = pend_r && (rec_key_q == key_r);
  assign rec_done   = !pend_r && (rptr_r >= rec_fill_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_tuser == REQ_LOOKUP) ? S_CACHE_SCAN : S_DONE;
        end
      end
      S_CACHE_SCAN: begin
        if (cache_hit) begin
          state_nxt = S_DONE;
        end else if (cache_done) begin
          state_nxt = S_RECORD_SCAN;
        end
      end
      S_RECORD_SCAN: begin
        if (rec_found || rec_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    rec_fill_nxt   = rec_fill_r;
    cache_fill_nxt = cache_fill_r;
    rptr_nxt       = rptr_r;
    cptr_nxt       = cptr_r;
    pend_nxt       = 1'b0;
    lookups_nxt    = lookups_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    rec_we         = 1'b0;
    cache_we       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt      = in_key;
          now_nxt      = in_now;
          cptr_nxt     = '0;
          res_addr_nxt = '0;
          if (in_tuser == REQ_LOOKUP) begin
            lookups_nxt = lookups_r + 1'b1;
          end else if (rec_fill_r == REC_FULL) begin
            res_status_nxt = ST_DROPPED;
          end else begin
            rec_we         = 1'b1;
            rec_fill_nxt   = rec_fill_r + 1'b1;
            res_status_nxt = ST_ADDED;
          end
        end
      end
      S_CACHE_SCAN: begin
        // issue entry cptr while checking the entry read last cycle
        if (cptr_r < cache_fill_r) begin
          pend_nxt = 1'b1;
          cptr_nxt = cptr_r + 1'b1;
        end
        if (cache_hit) begin
          pend_nxt       = 1'b0;
          hits_nxt       = hits_r + 1'b1;
          res_status_nxt = ST_HIT;
          res_addr_nxt   = cache_addr_q;
        end else if (cache_done) begin
          misses_nxt = misses_r + 1'b1;
          rptr_nxt   = '0;
        end
      end
      S_RECORD_SCAN: begin
        if (rptr_r < rec_fill_r) begin
          pend_nxt = 1'b1;
          rptr_nxt = rptr_r + 1'b1;
        end
        if (rec_found) begin
          pend_nxt       = 1'b0;
          res_status_nxt = ST_FOUND;
          res_addr_nxt   = rec_addr_q;
          if (cache_fill_r != CACHE_FULL) begin
            cache_we       = 1'b1;
            cache_fill_nxt = cache_fill_r + 1'b1;
          end
        end else if (rec_done) begin
          res_status_nxt = ST_NOT_FOUND;
          res_addr_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Record memory: write on add, one read per cycle for the scan
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_key_mem[rec_fill_r[RAW-1:0]]  <= in_key;
      rec_addr_mem[rec_fill_r[RAW-1:0]] <= in_addr;
    end
    rec_key_q  <= rec_key_mem[rptr_r[RAW-1:0]];
    rec_addr_q <= rec_addr_mem[rptr_r[RAW-1:0]];
  end

  // Cache memory: append on a found miss while not full, one read per cycle for the scan
  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_key_mem[cache_fill_r[CAW-1:0]]  <= key_r;
      cache_addr_mem[cache_fill_r[CAW-1:0]] <= rec_addr_q;
      cache_time_mem[cache_fill_r[CAW-1:0]] <= now_r;
    end
    cache_key_q  <= cache_key_mem[cptr_r[CAW-1:0]];
    cache_addr_q <= cache_addr_mem[cptr_r[CAW-1:0]];
    cache_time_q <= cache_time_mem[cptr_r[CAW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rec_fill_r   <= '0;
      cache_fill_r <= '0;
      rptr_r       <= '0;
      cptr_r       <= '0;
      pend_r       <= 1'b0;
      lookups_r    <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rec_fill_r   <= rec_fill_nxt;
      cache_fill_r <= cache_fill_nxt;
      rptr_r       <= rptr_nxt;
      cptr_r       <= cptr_nxt;
      pend_r       <= pend_nxt;
      lookups_r    <= lookups_nxt;
      hits_r       <= hits_nxt;
      misses_r     <= misses_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    if (out_load) begin
      out_data_r <= {misses_r, hits_r, lookups_r, res_addr_r};
      out_user_r <= res_status_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_TTL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_wr) begin
      ttl_r <= cfg_pwdata[TTL_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TTL) ? {16'd0, ttl_r} : '0;

endmodule

// ===== verif/ttl_lookup_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register channels of the name resolver,
// keeps its own copy of the record table, the TTL cache and the counters,
// and compares every result transfer with the oldest predicted answer.
module ttl_lookup_checker #(
  parameter int unsigned RECORD_DEPTH = 64,
  parameter int unsigned CACHE_DEPTH  = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [tcnl_pkg::IN_TDATA_W-1:0]      in_tdata,  // domain_key, address_in, now_seconds
  input  logic                                 in_tuser,  // req_type
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [tcnl_pkg::OUT_TDATA_W-1:0]     out_tdata, // result_address, lookups, hits, misses
  input  logic [tcnl_pkg::STATUS_W-1:0]        out_tuser, // status
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [tcnl_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [tcnl_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  input  logic [tcnl_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  input  logic                                 cfg_pready,
  output int                                   fail_count,
  output int                                   answers_owed
);
  import tcnl_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [IPV4_W-1:0] address;
    logic [CNT_W-1:0]  lookups;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
  } answer_t;

  // shadow of the record table
  logic [KEY_W-1:0]  rec_key  [RECORD_DEPTH];
  logic [IPV4_W-1:0] rec_addr [RECORD_DEPTH];
  int unsigned       rec_fill;

  // shadow of the TTL cache
  logic [KEY_W-1:0]  hot_key   [CACHE_DEPTH];
  logic [IPV4_W-1:0] hot_addr  [CACHE_DEPTH];
  logic [TIME_W-1:0] hot_stamp [CACHE_DEPTH];
  int unsigned       hot_fill;

  logic [CNT_W-1:0] n_lookups;
  logic [CNT_W-1:0] n_hits;
  logic [CNT_W-1:0] n_misses;
  logic [TTL_W-1:0] ttl;

  answer_t pending_answers[$];
  int unsigned results_checked;

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  // Apply one request to the shadow state and work out its answer
  function automatic answer_t resolve_request(input logic req,
                                              input logic [KEY_W-1:0] key,
                                              input logic [IPV4_W-1:0] addr_in,
                                              input logic [TIME_W-1:0] now);
    answer_t ans;
    logic [TIME_W-1:0] age;
    logic hit;
    logic found;
    int i;
    ans.status  = ST_ADDED;
    ans.address = '0;
    if (req == REQ_ADD) begin
      if (rec_fill >= RECORD_DEPTH) begin
        ans.status = ST_DROPPED;
      end else begin
        rec_key[rec_fill]  = key;
        rec_addr[rec_fill] = addr_in;
        rec_fill++;
      end
    end else begin
      n_lookups = n_lookups + 1'b1;
      hit = 1'b0;
      // first live cache entry wins; stale ones are skipped, never removed
      for (i = 0; i < hot_fill && !hit; i++) begin
        if (hot_key[i] == key) begin
          age = now - hot_stamp[i];
          if (age < TIME_W'(ttl)) begin
            hit         = 1'b1;
            ans.status  = ST_HIT;
            ans.address = hot_addr[i];
          end
        end
      end
      if (hit) begin
        n_hits = n_hits + 1'b1;
      end else begin
        n_misses   = n_misses + 1'b1;
        ans.status = ST_NOT_FOUND;
        found      = 1'b0;
        for (i = 0; i < rec_fill && !found; i++) begin
          if (rec_key[i] == key) begin
            found       = 1'b1;
            ans.status  = ST_FOUND;
            ans.address = rec_addr[i];
          end
        end
        // a full cache still answers, it just stops learning
        if (found && hot_fill < CACHE_DEPTH) begin
          hot_key[hot_fill]   = key;
          hot_addr[hot_fill]  = ans.address;
          hot_stamp[hot_fill] = now;
          hot_fill++;
        end
      end
    end
    ans.lookups = n_lookups;
    ans.hits    = n_hits;
    ans.misses  = n_misses;
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      rec_fill  = 0;
      hot_fill  = 0;
      n_lookups = '0;
      n_hits    = '0;
      n_misses  = '0;
      ttl       = TTL_RESET;
      pending_answers.delete();
    end else begin
      // register access
      if (cfg_psel && cfg_penable && cfg_pready && (cfg_paddr >> 2) == REG_TTL) begin
        if (cfg_pwrite)
          ttl = cfg_pwdata[TTL_W-1:0];
        else if (cfg_prdata !== CFG_DATA_W'(ttl))
          log_mismatch($sformatf("ttl read back %h, expected %h", cfg_prdata, ttl));
      end

      // result transfer
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          log_mismatch($sformatf("unexpected result, status %0d", out_tuser));
        end else begin
          want = pending_answers.pop_front();
          check_field("status", 32'(out_tuser), 32'(want.status));
          check_field("result_address", out_tdata[31:0], want.address);
          check_field("total_lookups", out_tdata[63:32], want.lookups);
          check_field("total_hits", out_tdata[95:64], want.hits);
          check_field("total_misses", out_tdata[127:96], want.misses);
        end
        results_checked++;
      end

      // request transfer
      if (in_tvalid && in_tready)
        pending_answers.push_back(resolve_request(in_tuser, in_tdata[63:0],
                                                  in_tdata[95:64], in_tdata[127:96]));
    end
    answers_owed <= pending_answers.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcnl_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] TTL_ADDR = CFG_ADDR_W'(REG_TTL) << 2;
  localparam int POOL_SIZE = 16;

  logic clk;
  logic rst_n = 1'b0;

  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;   // domain_key, address_in, now_seconds
  logic                    in_tuser = 1'b0; // req_type
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;       // result_address, lookups, hits, misses
  logic [STATUS_W-1:0]     out_tuser;       // status
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  int chk_fails;
  int answers_owed;
  int send_idle_pct = 10;
  int recv_idle_pct = 64;
  int adds_made = 0;

  logic [TTL_W-1:0]  ttl_now = TTL_RESET;
  logic [TIME_W-1:0] clock_now;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  logic [TIME_W-1:0] time_marks[$];

  ttl_cached_name_lookup DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ttl_lookup_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .fail_count   (chk_fails),
    .answers_owed (answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Present one request, with a random gap first, and hold it until the transfer
  task automatic send_item(input logic req, input logic [KEY_W-1:0] key,
                           input logic [IPV4_W-1:0] addr, input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {now, addr, key};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every answer has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
  endtask

  // Write the TTL register while idle, then read it back
  task automatic write_ttl(input logic [TTL_W-1:0] value);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TTL_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    ttl_now = value;
  endtask

  // Mostly adds and lookups over a small key pool with a slowly moving clock;
  // the rest are unknown keys, clock jumps and rewinds.
  task automatic run_traffic(input int count, input int s_pct, input int r_pct);
    int r;
    logic [KEY_W-1:0] key;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) begin
      if ($urandom_range(0, 99) < 85)
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        key = {$urandom, $urandom};
      if ($urandom_range(0, 99) < (adds_made < 72 ? 30 : 5)) begin
        send_item(REQ_ADD, key, $urandom, $urandom);
        adds_made++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3)
          clock_now = $urandom;
        else if (r < 6 && time_marks.size() > 0)
          clock_now = time_marks[$urandom_range(0, time_marks.size() - 1)]
                      + $urandom_range(0, ttl_now);
        else if (r < 8)
          clock_now = clock_now - $urandom_range(1, 1000);
        else
          clock_now = clock_now + $urandom_range(0, ttl_now / 32 + 1);
        if (time_marks.size() < 256) time_marks.push_back(clock_now);
        send_item(REQ_LOOKUP, key, $urandom, clock_now);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tables, duplicates, TTL boundary, clock wrap and rewind
    send_item(REQ_LOOKUP, '1, 32'h0, 32'h0);
    send_item(REQ_ADD, '1, 32'hFFFF_FFFF, 32'h0);
    send_item(REQ_ADD, '0, 32'h0, 32'hFFFF_FFFF);
    send_item(REQ_ADD, '1, 32'h1234_5678, 32'h0);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'd0);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'd299);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'd300);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'd301);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'hFFFF_FFFF);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'd5);
    send_item(REQ_LOOKUP, '0, 32'hFFFF_FFFF, 32'hFFFF_FF00);
    send_item(REQ_LOOKUP, '0, 32'h0, 32'h0000_0020);
    send_item(REQ_LOOKUP, '0, 32'h0, 32'h0000_0010);
    send_item(REQ_LOOKUP, '0, 32'h0, 32'hFFFF_FE00);
    send_item(REQ_LOOKUP, 64'hA5A5_5A5A_0F0F_F0F0, 32'h0, 32'h0000_0100);
    write_ttl(16'd1);
    send_item(REQ_LOOKUP, '0, 32'h0, 32'hFFFF_FE00);
    send_item(REQ_LOOKUP, '0, 32'h0, 32'hFFFF_FE01);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'hFFFF_FFFF);
    write_ttl(16'hFFFF);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'h0000_FFFE);
    send_item(REQ_LOOKUP, '1, 32'h0, 32'h0000_FFFF);
    adds_made = 3;

    // random traffic
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    clock_now = $urandom;
    run_traffic(400, 10, 64);
    write_ttl(16'd1);
    run_traffic(400, 64, 10);
    write_ttl(16'($urandom_range(2, 65534)));
    run_traffic(400, 0, 0);

    drain();
    repeat (200) @(posedge clk);
    if (chk_fails == 0 && answers_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tcnl_pkg.sv
hw/rtl/ttl_cached_name_lookup.sv
verif/ttl_lookup_checker.sv
verif/testbench.sv
